>>> hw/rtl/tsa_pkg.sv
// ============================================================================
// tsa_pkg
// Shared types, widths and constants for the triangle solid angle unit.
// ============================================================================
package tsa_pkg;

    // Input and output field widths.
    localparam int COORD_W = 24;
    localparam int SA_W    = 24;

    // Front datapath widths.
    localparam int PROD_W  = 2 * COORD_W;          // one coordinate product
    localparam int CR_W    = PROD_W + 1;           // cross product component
    localparam int DOT_W   = PROD_W + 2;           // dot product of two vertices
    localparam int NP_W    = CR_W + COORD_W;       // cross component times c
    localparam int LEN_W   = COORD_W;              // vector length
    localparam int LEN2_W  = 2 * LEN_W;            // product of two lengths
    localparam int LEN3_W  = 3 * LEN_W;            // product of three lengths
    localparam int DT_W    = DOT_W + LEN_W;        // dot product times length
    localparam int DS_W    = DT_W + 2;             // sum of three such terms
    localparam int WIDE_W  = 78;                   // numerator and denominator
    localparam int MAG_W   = WIDE_W - 1;           // their magnitudes
    localparam int SCALE_W = 31;                   // scaled magnitude bits

    // Leading-one search over the magnitudes, one byte per chunk.
    localparam int CHUNK_W   = 8;
    localparam int N_CHUNKS  = (MAG_W + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W     = N_CHUNKS * CHUNK_W;
    localparam int POS_W     = $clog2(CHUNK_W);
    localparam int BITLEN_W  = $clog2(PAD_W + 1);
    localparam int SHIFT_W   = $clog2(MAG_W - SCALE_W + 1);

    // Square root unit.
    localparam int SQRT_IN_W    = PROD_W;
    localparam int ROOT_W       = SQRT_IN_W / 2;
    localparam int REM_W        = ROOT_W + 1;
    localparam int SQRT_STEPS   = 3;
    localparam int SQRT_STAGES  = ROOT_W / SQRT_STEPS;

    // Front pipeline depth and the delay that keeps N and the dots aligned
    // with the lengths leaving the square root unit.
    localparam int FRONT_STAGES = 19;
    localparam int CARRY_DEPTH  = SQRT_STAGES - 1;

    // Queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // CORDIC back end.
    localparam int CORDIC_ITERATIONS = 24;
    localparam int CORDIC_STAGES     = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
    localparam int XY_W              = 35;
    localparam int ANG_W             = 35;
    localparam int START_Z_W         = 33;
    localparam logic signed [START_Z_W-1:0] ANG_PI = 33'sd3373259426;

    // Output rounding: 2*z in Q.30 to Q3.20 is a right shift by nine.
    localparam int ROUND_SHIFT = 9;
    localparam int ROUND_HALF  = 2 ** (ROUND_SHIFT - 1);
    localparam int Q_W         = ANG_W + 1 - ROUND_SHIFT;
    localparam logic signed [Q_W-1:0] SA_MAX_Q = Q_W'(2 ** (SA_W - 1) - 1);
    localparam logic signed [Q_W-1:0] SA_MIN_Q = -Q_W'(2 ** (SA_W - 1));

    // Arctangent of 2^-i in Q.30 radians, rounded to nearest.
    localparam logic signed [ANG_W-1:0] ATAN_TAB [32] = '{
        35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
        35'sd67021687,  35'sd33543516,  35'sd16775851,  35'sd8388437,
        35'sd4194283,   35'sd2097149,   35'sd1048576,   35'sd524288,
        35'sd262144,    35'sd131072,    35'sd65536,     35'sd32768,
        35'sd16384,     35'sd8192,      35'sd4096,      35'sd2048,
        35'sd1024,      35'sd512,       35'sd256,       35'sd128,
        35'sd64,        35'sd32,        35'sd16,        35'sd8,
        35'sd4,         35'sd2,         35'sd1,         35'sd0
    };

    // One input item: three vertices relative to the observer, Q8.16.
    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by_coord;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
    } tsa_in_t;

    // One result item.
    typedef struct packed {
        logic signed [SA_W-1:0] solid_angle;
        logic                   degenerate;
    } tsa_out_t;

    // Starting vector and angle handed from the front to the CORDIC.
    typedef struct packed {
        logic signed [SCALE_W:0]     x;
        logic signed [SCALE_W:0]     y;
        logic signed [START_Z_W-1:0] z;
        logic                        degenerate;
    } cordic_in_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

>>> hw/rtl/tsa_isqrt.sv
// ============================================================================
// tsa_isqrt
// Pipelined integer square root, floor(sqrt(radicand)), three result bits
// per stage.
// ============================================================================
module tsa_isqrt
    import tsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [SQRT_IN_W-1:0] radicand,
    output logic [ROOT_W-1:0]    root
);

    logic [SQRT_IN_W-1:0] rad_reg  [SQRT_STAGES];
    logic [REM_W-1:0]     rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0]    root_reg [SQRT_STAGES];

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
        logic [SQRT_IN_W-1:0] rad_in;
        logic [REM_W-1:0]     rem_in;
        logic [ROOT_W-1:0]    root_in;
        logic [REM_W-1:0]     rem_next;
        logic [ROOT_W-1:0]    root_next;

        if (g == 0) begin : g_first
            assign rad_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else begin : g_rest
            assign rad_in  = rad_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
        end

        // Restoring digit recurrence: bring down two bits, try root*4+1.
        always_comb
        begin
            logic [REM_W+1:0] acc;
            logic [REM_W+1:0] trial;
            rem_next  = rem_in;
            root_next = root_in;
            acc       = '0;
            trial     = '0;
            for (int j = 0; j < SQRT_STEPS; j++)
            begin
                acc   = {rem_next, rad_in[2 * (ROOT_W - 1 - (g * SQRT_STEPS + j)) +: 2]};
                trial = (REM_W + 2)'({root_next, 2'b01});
                if (acc >= trial)
                begin
                    rem_next  = REM_W'(acc - trial);
                    root_next = {root_next[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = REM_W'(acc);
                    root_next = {root_next[ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[g]  <= rad_in;
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule

>>> hw/rtl/tsa_front.sv
// ============================================================================
// tsa_front
// Front pipeline: takes each item, forms the triple product N and the
// denominator D, scales both to 31 bits and picks the starting quadrant.
// ============================================================================
module tsa_front
    import tsa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  tsa_in_t      item,
    input  fifo_status_t fifo_stat,
    output logic         push,
    output cordic_in_t   push_data
);

    typedef struct packed {
        logic signed [WIDE_W-1:0] num;
        logic signed [DOT_W-1:0]  ab;
        logic signed [DOT_W-1:0]  ac;
        logic signed [DOT_W-1:0]  bc;
    } carry_t;

    typedef struct packed {
        logic nneg;
        logic dneg;
        logic deg;
    } sign_flags_t;

    logic                      en;
    logic [FRONT_STAGES-1:0]   vld_reg;

    tsa_in_t                   in_reg;
    logic signed [COORD_W-1:0] av [3];
    logic signed [COORD_W-1:0] bv [3];
    logic signed [COORD_W-1:0] cv [3];

    logic signed [PROD_W-1:0]  sq_reg  [9];
    logic signed [PROD_W-1:0]  crp_reg [6];
    logic signed [PROD_W-1:0]  dab_reg [3];
    logic signed [PROD_W-1:0]  dac_reg [3];
    logic signed [PROD_W-1:0]  dbc_reg [3];
    logic signed [COORD_W-1:0] c2_reg  [3];

    logic [SQRT_IN_W-1:0]      ss_reg  [3];
    logic signed [CR_W-1:0]    cr_reg  [3];
    logic signed [DOT_W-1:0]   ab3_reg;
    logic signed [DOT_W-1:0]   ac3_reg;
    logic signed [DOT_W-1:0]   bc3_reg;
    logic signed [COORD_W-1:0] c3_reg  [3];

    logic signed [NP_W-1:0]    np_reg  [3];
    logic signed [DOT_W-1:0]   ab4_reg;
    logic signed [DOT_W-1:0]   ac4_reg;
    logic signed [DOT_W-1:0]   bc4_reg;

    carry_t                    carry_reg [CARRY_DEPTH];
    logic [LEN_W-1:0]          len [3];

    logic [LEN2_W-1:0]         abn_reg;
    logic signed [DT_W-1:0]    tab_reg;
    logic signed [DT_W-1:0]    tac_reg;
    logic signed [DT_W-1:0]    tbc_reg;
    logic [LEN_W-1:0]          cn12_reg;
    logic signed [WIDE_W-1:0]  num12_reg;

    logic [LEN3_W-1:0]         abc_reg;
    logic signed [DS_W-1:0]    dsum_reg;
    logic signed [WIDE_W-1:0]  num13_reg;

    logic signed [WIDE_W-1:0]  den14_reg;
    logic signed [WIDE_W-1:0]  num14_reg;

    logic [MAG_W-1:0]          mn15_reg;
    logic [MAG_W-1:0]          md15_reg;
    sign_flags_t               flg15_reg;

    logic [N_CHUNKS-1:0]       nz_next;
    logic [POS_W-1:0]          pos_next [N_CHUNKS];
    logic [N_CHUNKS-1:0]       nz_reg;
    logic [POS_W-1:0]          pos_reg  [N_CHUNKS];
    logic [MAG_W-1:0]          mn16_reg;
    logic [MAG_W-1:0]          md16_reg;
    sign_flags_t               flg16_reg;

    logic [BITLEN_W-1:0]       bitlen;
    logic [SHIFT_W-1:0]        shift_next;
    logic [SHIFT_W-1:0]        shift_reg;
    logic [MAG_W-1:0]          mn17_reg;
    logic [MAG_W-1:0]          md17_reg;
    sign_flags_t               flg17_reg;

    logic [SCALE_W-1:0]        t1_reg;
    logic [SCALE_W-1:0]        t2_reg;
    sign_flags_t               flg18_reg;

    logic signed [SCALE_W:0]   t1_s;
    logic signed [SCALE_W:0]   t2_s;
    cordic_in_t                push_data_reg;

    // The whole front moves together and holds while the queue is full.
    assign en         = !fifo_stat.full;
    assign item_ready = en;
    assign push       = en && vld_reg[FRONT_STAGES-1];
    assign push_data  = push_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], item_valid};
        end
    end

    assign av[0] = in_reg.ax;
    assign av[1] = in_reg.ay;
    assign av[2] = in_reg.az;
    assign bv[0] = in_reg.bx;
    assign bv[1] = in_reg.by_coord;
    assign bv[2] = in_reg.bz;
    assign cv[0] = in_reg.cx;
    assign cv[1] = in_reg.cy;
    assign cv[2] = in_reg.cz;

    // Lengths of the three vertices, aligned with the last carry stage.
    for (genvar k = 0; k < 3; k++) begin : g_len
        tsa_isqrt u_isqrt (
            .clk      (clk),
            .en       (en),
            .radicand (ss_reg[k]),
            .root     (len[k])
        );
    end

    // Leading-one position within each byte of the combined magnitude.
    always_comb
    begin
        logic [PAD_W-1:0] padded;
        padded = PAD_W'(mn15_reg | md15_reg);
        for (int c = 0; c < N_CHUNKS; c++)
        begin
            nz_next[c]  = |padded[c * CHUNK_W +: CHUNK_W];
            pos_next[c] = '0;
            for (int b = 0; b < CHUNK_W; b++)
            begin
                if (padded[c * CHUNK_W + b])
                begin
                    pos_next[c] = POS_W'(b);
                end
            end
        end
    end

    // Smallest common shift that brings both magnitudes below 2^31.
    always_comb
    begin
        bitlen = '0;
        for (int c = 0; c < N_CHUNKS; c++)
        begin
            if (nz_reg[c])
            begin
                bitlen = BITLEN_W'(c * CHUNK_W) + BITLEN_W'(pos_reg[c]) + BITLEN_W'(1);
            end
        end
        shift_next = (bitlen > BITLEN_W'(SCALE_W)) ? SHIFT_W'(bitlen - BITLEN_W'(SCALE_W))
                                                  : '0;
    end

    assign t1_s = $signed({1'b0, t1_reg});
    assign t2_s = $signed({1'b0, t2_reg});

    // Datapath stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Capture the item.
            in_reg <= item;

            // Coordinate products.
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k]     <= PROD_W'(av[k]) * PROD_W'(av[k]);
                sq_reg[k + 3] <= PROD_W'(bv[k]) * PROD_W'(bv[k]);
                sq_reg[k + 6] <= PROD_W'(cv[k]) * PROD_W'(cv[k]);
                dab_reg[k]    <= PROD_W'(av[k]) * PROD_W'(bv[k]);
                dac_reg[k]    <= PROD_W'(av[k]) * PROD_W'(cv[k]);
                dbc_reg[k]    <= PROD_W'(bv[k]) * PROD_W'(cv[k]);
                c2_reg[k]     <= cv[k];
            end
            crp_reg[0] <= PROD_W'(av[1]) * PROD_W'(bv[2]);
            crp_reg[1] <= PROD_W'(av[2]) * PROD_W'(bv[1]);
            crp_reg[2] <= PROD_W'(av[2]) * PROD_W'(bv[0]);
            crp_reg[3] <= PROD_W'(av[0]) * PROD_W'(bv[2]);
            crp_reg[4] <= PROD_W'(av[0]) * PROD_W'(bv[1]);
            crp_reg[5] <= PROD_W'(av[1]) * PROD_W'(bv[0]);

            // Squared lengths, cross product a x b and the three dots.
            for (int k = 0; k < 3; k++)
            begin
                ss_reg[k] <= $unsigned(sq_reg[3 * k]) + $unsigned(sq_reg[3 * k + 1])
                           + $unsigned(sq_reg[3 * k + 2]);
                cr_reg[k] <= CR_W'(crp_reg[2 * k]) - CR_W'(crp_reg[2 * k + 1]);
                c3_reg[k] <= c2_reg[k];
            end
            ab3_reg <= DOT_W'(dab_reg[0]) + DOT_W'(dab_reg[1]) + DOT_W'(dab_reg[2]);
            ac3_reg <= DOT_W'(dac_reg[0]) + DOT_W'(dac_reg[1]) + DOT_W'(dac_reg[2]);
            bc3_reg <= DOT_W'(dbc_reg[0]) + DOT_W'(dbc_reg[1]) + DOT_W'(dbc_reg[2]);

            // Triple product terms.
            for (int k = 0; k < 3; k++)
            begin
                np_reg[k] <= NP_W'(cr_reg[k]) * NP_W'(c3_reg[k]);
            end
            ab4_reg <= ab3_reg;
            ac4_reg <= ac3_reg;
            bc4_reg <= bc3_reg;

            // Numerator, then delay it with the dots until the lengths arrive.
            carry_reg[0].num <= WIDE_W'(np_reg[0]) + WIDE_W'(np_reg[1]) + WIDE_W'(np_reg[2]);
            carry_reg[0].ab  <= ab4_reg;
            carry_reg[0].ac  <= ac4_reg;
            carry_reg[0].bc  <= bc4_reg;
            for (int i = 1; i < CARRY_DEPTH; i++)
            begin
                carry_reg[i] <= carry_reg[i-1];
            end

            // Denominator products.
            abn_reg   <= LEN2_W'(len[0]) * LEN2_W'(len[1]);
            tab_reg   <= DT_W'(carry_reg[CARRY_DEPTH-1].ab) * DT_W'($signed({1'b0, len[2]}));
            tac_reg   <= DT_W'(carry_reg[CARRY_DEPTH-1].ac) * DT_W'($signed({1'b0, len[1]}));
            tbc_reg   <= DT_W'(carry_reg[CARRY_DEPTH-1].bc) * DT_W'($signed({1'b0, len[0]}));
            cn12_reg  <= len[2];
            num12_reg <= carry_reg[CARRY_DEPTH-1].num;

            abc_reg   <= LEN3_W'(abn_reg) * LEN3_W'(cn12_reg);
            dsum_reg  <= DS_W'(tab_reg) + DS_W'(tac_reg) + DS_W'(tbc_reg);
            num13_reg <= num12_reg;

            den14_reg <= WIDE_W'($signed({1'b0, abc_reg})) + WIDE_W'(dsum_reg);
            num14_reg <= num13_reg;

            // Signs, magnitudes and the both-zero case.
            flg15_reg.nneg <= num14_reg[WIDE_W-1];
            flg15_reg.dneg <= den14_reg[WIDE_W-1];
            flg15_reg.deg  <= (num14_reg == '0) && (den14_reg == '0);
            mn15_reg <= num14_reg[WIDE_W-1] ? MAG_W'(-num14_reg) : MAG_W'(num14_reg);
            md15_reg <= den14_reg[WIDE_W-1] ? MAG_W'(-den14_reg) : MAG_W'(den14_reg);

            nz_reg    <= nz_next;
            pos_reg   <= pos_next;
            mn16_reg  <= mn15_reg;
            md16_reg  <= md15_reg;
            flg16_reg <= flg15_reg;

            shift_reg <= shift_next;
            mn17_reg  <= mn16_reg;
            md17_reg  <= md16_reg;
            flg17_reg <= flg16_reg;

            // Scale down, truncating toward zero on the magnitudes.
            t1_reg    <= SCALE_W'(mn17_reg >> shift_reg);
            t2_reg    <= SCALE_W'(md17_reg >> shift_reg);
            flg18_reg <= flg17_reg;

            // Restore signs; a negative D flips the vector and starts at +/-pi.
            push_data_reg.x <= flg18_reg.dneg ? -t2_s : t2_s;
            push_data_reg.y <= (flg18_reg.nneg ^ flg18_reg.dneg) ? -t1_s : t1_s;
            if (flg18_reg.dneg)
            begin
                push_data_reg.z <= flg18_reg.nneg ? -ANG_PI : ANG_PI;
            end
            else
            begin
                push_data_reg.z <= '0;
            end
            push_data_reg.degenerate <= flg18_reg.deg;
        end
    end

endmodule

>>> hw/rtl/tsa_fifo.sv
// ============================================================================
// tsa_fifo
// Short queue of CORDIC start vectors between the front and the back.
// ============================================================================
module tsa_fifo
    import tsa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  cordic_in_t   push_data,
    input  logic         pop,
    output cordic_in_t   head,
    output fifo_status_t stat
);

    cordic_in_t         entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_reg;
    logic [FIFO_AW-1:0] rd_reg;
    logic [FIFO_AW:0]   cnt_reg;
    logic [FIFO_AW:0]   cnt_next;

    assign head       = entry_reg[rd_reg];
    assign stat.full  = (cnt_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);

    // Occupancy follows pushes and pops.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/tsa_cordic.sv
// ============================================================================
// tsa_cordic
// Back pipeline: one vectoring CORDIC iteration per stage, then doubling,
// rounding and saturation into the result register.
// ============================================================================
module tsa_cordic
    import tsa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cordic_in_t   head,
    input  fifo_status_t fifo_stat,
    output logic         pop,
    output logic         result_valid,
    input  logic         result_ready,
    output tsa_out_t     result
);

    logic                   en;
    logic [CORDIC_STAGES:0] vld_reg;
    logic signed [XY_W-1:0] x_reg [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] y_reg [CORDIC_STAGES+1];
    logic signed [ANG_W-1:0] z_reg [CORDIC_STAGES+1];
    logic                   deg_reg [CORDIC_STAGES+1];

    logic signed [ANG_W:0]  rnd;
    logic signed [Q_W-1:0]  q;
    logic signed [SA_W-1:0] sa_next;
    logic                   result_valid_reg;
    tsa_out_t               result_reg;

    // The back moves as one whenever the result register can take an item.
    assign en           = !result_valid_reg || result_ready;
    assign pop          = en && !fifo_stat.empty;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg          <= {vld_reg[CORDIC_STAGES-1:0], !fifo_stat.empty};
            result_valid_reg <= vld_reg[CORDIC_STAGES];
        end
    end

    // Load the start vector from the queue.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= XY_W'(head.x);
            y_reg[0]   <= XY_W'(head.y);
            z_reg[0]   <= ANG_W'(head.z);
            deg_reg[0] <= head.degenerate;
        end
    end

    // Vectoring iterations: drive y toward zero, accumulate the angle.
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_iter
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;

        assign xs = x_reg[g] >>> g;
        assign ys = y_reg[g] >>> g;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_reg[g][XY_W-1])
                begin
                    x_reg[g+1] <= x_reg[g] + ys;
                    y_reg[g+1] <= y_reg[g] - xs;
                    z_reg[g+1] <= z_reg[g] + ATAN_TAB[g];
                end
                else
                begin
                    x_reg[g+1] <= x_reg[g] - ys;
                    y_reg[g+1] <= y_reg[g] + xs;
                    z_reg[g+1] <= z_reg[g] - ATAN_TAB[g];
                end
                deg_reg[g+1] <= deg_reg[g];
            end
        end
    end

    // Twice the angle in Q3.20, rounded, then clamped to the field.
    always_comb
    begin
        rnd = (ANG_W + 1)'(z_reg[CORDIC_STAGES]) + (ANG_W + 1)'(ROUND_HALF);
        q   = $signed(rnd[ANG_W:ROUND_SHIFT]);
        if (q > SA_MAX_Q)
        begin
            sa_next = SA_MAX_Q[SA_W-1:0];
        end
        else if (q < SA_MIN_Q)
        begin
            sa_next = SA_MIN_Q[SA_W-1:0];
        end
        else
        begin
            sa_next = q[SA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg.solid_angle <= deg_reg[CORDIC_STAGES] ? '0 : sa_next;
            result_reg.degenerate  <= deg_reg[CORDIC_STAGES];
        end
    end

endmodule

>>> hw/rtl/triangle_solid_angle_unit.sv
// ============================================================================
// triangle_solid_angle_unit
// Signed solid angle of a triangle seen from the origin, by the Van
// Oosterom-Strackee formula: 2*atan2((a x b).c, |a||b||c| + (a.b)|c| +
// (a.c)|b| + (b.c)|a|), with Q8.16 vertex inputs and a Q3.20 result.
// The unit takes one item per clock while item_ready is high and returns
// one result per item, in order. An item passes through 19 front stages
// (products, a three-bit-per-stage square root for the lengths, the wide
// numerator and denominator sums, and the common scaling shift), the
// four-entry queue, and 26 back stages (load, 24 CORDIC iterations,
// rounding). When result_ready is low the back holds, the queue fills and
// then item_ready drops. A triangle whose numerator and denominator are
// both zero returns 0 with degenerate set.
// ============================================================================
module triangle_solid_angle_unit
    import tsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  tsa_in_t  item,
    output logic     result_valid,
    input  logic     result_ready,
    output tsa_out_t result
);

    logic         fifo_push;
    logic         fifo_pop;
    cordic_in_t   fifo_in;
    cordic_in_t   fifo_head;
    fifo_status_t fifo_stat;

    // Front: geometry, scaling and quadrant selection.
    tsa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .fifo_stat  (fifo_stat),
        .push       (fifo_push),
        .push_data  (fifo_in)
    );

    // Queue between front and back.
    tsa_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (fifo_in),
        .pop       (fifo_pop),
        .head      (fifo_head),
        .stat      (fifo_stat)
    );

    // Back: CORDIC arctangent and output register.
    tsa_cordic u_cordic (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (fifo_head),
        .fifo_stat    (fifo_stat),
        .pop          (fifo_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef SYNTHESIS
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.degenerate |-> result.solid_angle == '0)
        else $error("degenerate result with nonzero angle");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> !fifo_stat.empty)
        else $error("queue popped while empty");

    a_fifo_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_stat.full && fifo_stat.empty))
        else $error("queue reports full and empty together");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> fifo_stat.full && !fifo_push)
        else $error("front stalled without a full queue");
`endif

endmodule

>>> tb/triangle_solid_angle_unit_tb.sv
// ============================================================================
// triangle_solid_angle_unit_tb
// Self-checking bench for the triangle solid angle unit. A bit-exact
// Van Oosterom-Strackee predictor computes each expected result when an item
// is accepted. A short directed set covers extreme, degenerate and
// back-facing triangles. Random triangles follow, with random gaps and
// stalls on both sides, one long output stall, and one full drain.
// ============================================================================
module triangle_solid_angle_unit_tb;
    import tsa_pkg::*;

    localparam int N_RANDOM   = 1400;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 120;

    // Scoreboard: predicts solid angles and holds them until they come out.
    class angle_scoreboard;
        tsa_out_t expected_q[$];
        int       errors = 0;

        function automatic logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function automatic longint vec_len(longint x, longint y, longint z);
            return longint'(int_sqrt(64'(x * x) + 64'(y * y) + 64'(z * z)));
        endfunction

        function automatic tsa_out_t solid_angle_of(tsa_in_t v);
            longint ax, ay, az, bx, by, bz, cx, cy, cz;
            longint an, bn, cn, crx, cry, crz, x, y, z, xs, ys, q;
            logic signed [127:0] num, den;
            logic [127:0] mn, md;
            int sh;
            tsa_out_t r;
            ax = v.ax; ay = v.ay; az = v.az;
            bx = v.bx; by = v.by_coord; bz = v.bz;
            cx = v.cx; cy = v.cy; cz = v.cz;
            an = vec_len(ax, ay, az);
            bn = vec_len(bx, by, bz);
            cn = vec_len(cx, cy, cz);
            crx = ay * bz - az * by;
            cry = az * bx - ax * bz;
            crz = ax * by - ay * bx;

            // Exact numerator and denominator at scale 2^-48.
            num = 128'(signed'(crx)) * 128'(signed'(cx)) + 128'(signed'(cry)) * 128'(signed'(cy))
                + 128'(signed'(crz)) * 128'(signed'(cz));
            den = 128'(signed'(an * bn)) * 128'(signed'(cn))
                + 128'(signed'(ax * bx + ay * by + az * bz)) * 128'(signed'(cn))
                + 128'(signed'(ax * cx + ay * cy + az * cz)) * 128'(signed'(bn))
                + 128'(signed'(bx * cx + by * cy + bz * cz)) * 128'(signed'(an));
            if (num == 0 && den == 0)
            begin
                r.solid_angle = '0;
                r.degenerate  = 1'b1;
                return r;
            end

            // Common scaling of both magnitudes below 2^31.
            mn = num[127] ? -num : num;
            md = den[127] ? -den : den;
            sh = 0;
            while ((mn >> sh) >= 128'd2147483648 || (md >> sh) >= 128'd2147483648)
                sh++;
            y = longint'(mn >> sh);
            x = longint'(md >> sh);
            z = 0;
            if (num[127])
                y = -y;
            if (den[127])
            begin
                x = -x;
                y = -y;
                z = num[127] ? -longint'(ANG_PI) : longint'(ANG_PI);
            end

            // Vectoring rotations.
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(ATAN_TAB[i]);
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(ATAN_TAB[i]);
                end
            end
            q = (z + 256) >>> 9;
            if (q > 8388607)
                q = 8388607;
            if (q < -8388608)
                q = -8388608;
            r.solid_angle = q[SA_W-1:0];
            r.degenerate  = 1'b0;
            return r;
        endfunction

        function void note_item(tsa_in_t v);
            expected_q.push_back(solid_angle_of(v));
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(tsa_out_t got);
            tsa_out_t want;
            if (expected_q.size() == 0)
            begin
                report("result with nothing expected");
                return;
            end
            want = expected_q.pop_front();
            if (got.solid_angle !== want.solid_angle)
                report($sformatf("solid_angle got %0d want %0d",
                                 got.solid_angle, want.solid_angle));
            if (got.degenerate !== want.degenerate)
                report($sformatf("degenerate got %0b want %0b",
                                 got.degenerate, want.degenerate));
        endtask
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     item_valid = 1'b0;
    logic     item_ready;
    tsa_in_t  item = '0;
    logic     result_valid;
    logic     result_ready = 1'b0;
    tsa_out_t result;

    angle_scoreboard sb = new();
    int  items_in = 0;
    int  idle_cycles = 0;
    bit  drained_once = 1'b0;

    triangle_solid_angle_unit DUT (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Monitor both handshakes and watch for a hang.
    always @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            sb.note_item(item);
            items_in++;
        end
        if (result_valid && result_ready)
            sb.check_result(result);
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles = 0;
        else if (rst_n)
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55)
            return 0;
        else if (p < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    // Receiver: random stalls, plus one long hold-off to back the unit up.
    initial
    begin
        int g;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && items_in >= 300)
            begin
                held = 1'b1;
                result_ready <= 1'b0;
                repeat (250) @(posedge clk);
            end
            result_ready <= 1'b1;
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(12, 1)) @(posedge clk);
            else
            begin
                @(posedge clk);
                g = gap_len();
                if (g > 0)
                begin
                    result_ready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
            end
        end
    end

    task automatic send_item(tsa_in_t v);
        int g;
        item       <= v;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        g = gap_len();
        if (g > 0)
        begin
            item_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
        case (mode)
            0: return COORD_W'($urandom);
            1: return COORD_W'($signed($urandom_range(262143)) - 131072);
            2: return COORD_W'($signed($urandom_range(31)) - 16);
            default: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
        endcase
    endfunction

    function automatic tsa_in_t rand_triangle();
        tsa_in_t v;
        int mode, shape;
        mode = $urandom_range(9);
        mode = mode < 4 ? 0 : (mode < 7 ? 1 : (mode < 9 ? 2 : 3));
        v.ax = rand_coord(mode); v.ay = rand_coord(mode); v.az = rand_coord(mode);
        v.bx = rand_coord(mode); v.by_coord = rand_coord(mode); v.bz = rand_coord(mode);
        v.cx = rand_coord(mode); v.cy = rand_coord(mode); v.cz = rand_coord(mode);
        shape = $urandom_range(19);
        // Flat triangles: repeated vertex, a zero vertex, or opposite vertices.
        if (shape == 0)
        begin
            v.bx = v.ax; v.by_coord = v.ay; v.bz = v.az;
        end
        else if (shape == 1)
        begin
            v.cx = '0; v.cy = '0; v.cz = '0;
        end
        else if (shape == 2 && v.ax != 24'sh800000 && v.ay != 24'sh800000
                 && v.az != 24'sh800000)
        begin
            v.cx = -v.ax; v.cy = -v.ay; v.cz = -v.az;
        end
        return v;
    endfunction

    function automatic tsa_in_t tri_of(int a0, int a1, int a2, int b0, int b1, int b2,
                                       int c0, int c1, int c2);
        tsa_in_t v;
        v.ax = COORD_W'(a0); v.ay = COORD_W'(a1); v.az = COORD_W'(a2);
        v.bx = COORD_W'(b0); v.by_coord = COORD_W'(b1); v.bz = COORD_W'(b2);
        v.cx = COORD_W'(c0); v.cy = COORD_W'(c1); v.cz = COORD_W'(c2);
        return v;
    endfunction

    // Stimulus.
    initial
    begin
        localparam int ONE = 65536;
        localparam int MX  = 8388607;
        localparam int MN  = -8388608;
        tsa_in_t dir_q[$];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Degenerate: all zero, and one zero vertex.
        dir_q.push_back(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_q.push_back(tri_of(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        // Octant triangle and its mirror.
        dir_q.push_back(tri_of(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
        dir_q.push_back(tri_of(ONE, 0, 0, 0, 0, ONE, 0, ONE, 0));
        // Back-facing triangles with a negative denominator, then a degenerate a, -a pair.
        dir_q.push_back(tri_of(ONE, 1, 0, -ONE, 1, 0, 0, -ONE, 10));
        dir_q.push_back(tri_of(ONE, 1, 0, -ONE, 1, 0, 0, -ONE, -10));
        dir_q.push_back(tri_of(ONE, 0, 0, -ONE, 0, 0, 0, ONE, 0));
        // Field extremes.
        dir_q.push_back(tri_of(MX, MX, MX, MX, MX, MX, MX, MX, MX));
        dir_q.push_back(tri_of(MN, MN, MN, MN, MN, MN, MN, MN, MN));
        dir_q.push_back(tri_of(MX, 0, 0, 0, MN, 0, 0, 0, MX));
        dir_q.push_back(tri_of(MN, 0, 0, 0, MX, 0, 0, 0, MN));
        dir_q.push_back(tri_of(MX, MN, MX, MN, MX, MN, MX, MN, MX));
        dir_q.push_back(tri_of(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        dir_q.push_back(tri_of(1, 0, 0, 0, 1, 0, 0, 0, 1));
        dir_q.push_back(tri_of(MX, MX, 1, MN, MX, 1, MX, MN, 1));
        dir_q.push_back(tri_of(1, 2, 3, 2, 4, 6, -3, -6, -9));
        dir_q.push_back(tri_of(ONE, ONE, ONE, -ONE, ONE, ONE, 0, -ONE, ONE));
        dir_q.push_back(tri_of(ONE, ONE, -ONE, ONE, -ONE, -ONE, -ONE, 0, -ONE));
        foreach (dir_q[i])
            send_item(dir_q[i]);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // Once, let the unit empty out completely before going on.
            if (!drained_once && n == 700)
            begin
                drained_once = 1'b1;
                item_valid <= 1'b0;
                @(posedge clk);
                while (sb.expected_q.size() != 0)
                    @(posedge clk);
            end
            send_item(rand_triangle());
        end
        item_valid <= 1'b0;
        @(posedge clk);

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
